// ===== src/frustum_cull_sphere_box_test_defines.svh =====
// Assertion macros for the frustum cull block.
// Included by modules that check their own logic; no other dependencies.
`ifndef FRUSTUM_CULL_SPHERE_BOX_TEST_DEFINES_SVH
`define FRUSTUM_CULL_SPHERE_BOX_TEST_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on the rising clock edge, idle while reset is high
`define FCSB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check a property on the rising clock edge, also while reset is high
`define FCSB_ASSERT_NR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define FCSB_ASSERT(lbl, prop, msg)
`define FCSB_ASSERT_NR(lbl, prop, msg)
`endif

`endif

// ===== src/fcsb_pkg.sv =====
// Types and constants shared by the frustum cull block and its channel interfaces.
// No dependencies.
package fcsb_pkg;

   localparam int NUM_PLANES  = 6;
   localparam int NUM_AXES    = 3;
   localparam int ALIGN_SHIFT = 14;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   typedef logic signed [15:0] coord_type;
   typedef logic [14:0]        radius_type;
   typedef logic signed [15:0] normal_type;
   typedef logic signed [16:0] offset_type;
   typedef logic signed [31:0] prod_type;
   typedef logic signed [32:0] partial_type;
   typedef logic signed [33:0] total_type;
   typedef logic [63:0]        plane_type;
   typedef logic [2:0]         reg_index_type;

   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

   // Register map indexes
   localparam reg_index_type REG_PLANE_RIGHT  = 3'd0;
   localparam reg_index_type REG_PLANE_LEFT   = 3'd1;
   localparam reg_index_type REG_PLANE_BOTTOM = 3'd2;
   localparam reg_index_type REG_PLANE_TOP    = 3'd3;
   localparam reg_index_type REG_PLANE_FAR    = 3'd4;
   localparam reg_index_type REG_PLANE_NEAR   = 3'd5;
   localparam reg_index_type REG_CULL_ENABLE  = 3'd6;

   // Request kinds
   localparam logic REQ_SPHERE = 1'b0;
   localparam logic REQ_BOX    = 1'b1;

endpackage

// ===== src/fcsb_req_if.sv =====
// Request channel: valid/ready handshake carrying one sphere or box item.
// Depends on fcsb_pkg.
interface fcsb_req_if;
   import fcsb_pkg::*;

   logic       valid;
   logic       ready;
   logic       req_type;
   coord_type  first_x;
   coord_type  first_y;
   coord_type  first_z;
   coord_type  second_x;
   coord_type  second_y;
   coord_type  second_z;
   radius_type sphere_radius;

   modport source (
      output valid, req_type, first_x, first_y, first_z,
             second_x, second_y, second_z, sphere_radius,
      input  ready
   );
   modport sink (
      input  valid, req_type, first_x, first_y, first_z,
             second_x, second_y, second_z, sphere_radius,
      output ready
   );
endinterface

// ===== src/fcsb_rsp_if.sv =====
// Response channel: valid/ready handshake carrying the visibility flag.
// Depends on fcsb_pkg.
interface fcsb_rsp_if;
   import fcsb_pkg::*;

   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, visible, input ready);
   modport sink (input valid, visible, output ready);
endinterface

// ===== src/frustum_cull_sphere_box_test.sv =====
// Four register stages: multiply, per-axis select, partial add, final add and compare.
// Throughput: one item per cycle while the response consumer does not stall.
// Reset (synchronous, active high) empties the pipeline, clears all planes
// to zero and sets cull_enable to one.
// Depends on fcsb_pkg, fcsb_req_if, fcsb_rsp_if and the defines header.
`include "frustum_cull_sphere_box_test_defines.svh"

module frustum_cull_sphere_box_test (
   input  logic                  clock,
   input  logic                  reset,
   fcsb_req_if.sink              req_ch,
   fcsb_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  fcsb_pkg::csr_addr_type csr_paddr,
   input  fcsb_pkg::csr_data_type csr_pwdata,
   output fcsb_pkg::csr_data_type csr_prdata,
   output logic                  csr_pready
);
   import fcsb_pkg::*;

   // Configuration registers
   plane_type     plane_ff [NUM_PLANES];
   logic          cull_enable_ff;
   reg_index_type csr_index;
   logic          csr_write;

   // Pipeline stage 1: products
   logic       v1_ff;
   logic       type1_ff;
   radius_type radius1_ff;
   prod_type   prod_a_ff [NUM_PLANES][NUM_AXES];
   prod_type   prod_b_ff [NUM_PLANES][NUM_AXES];

   // Pipeline stage 2: per-axis terms and offsets
   logic       v2_ff;
   logic       type2_ff;
   prod_type   term_ff [NUM_PLANES][NUM_AXES];
   offset_type offset_ff [NUM_PLANES];

   // Pipeline stage 3: partial sums
   logic        v3_ff;
   logic        type3_ff;
   partial_type part_a_ff [NUM_PLANES];
   partial_type part_b_ff [NUM_PLANES];

   // Output stage
   logic out_v_ff;
   logic out_vis_ff;
   logic out_type_ff;
   logic out_vis_in;

   logic rdy1, rdy2, rdy3, rdy4;
   coord_type first_c  [NUM_AXES];
   coord_type second_c [NUM_AXES];
   logic [NUM_PLANES-1:0] culled;
   total_type total [NUM_PLANES];

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Write planes and cull enable; ignore indexes past the map
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            plane_ff[p] <= '0;
         end
         cull_enable_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index) inside
            REG_PLANE_RIGHT, REG_PLANE_LEFT, REG_PLANE_BOTTOM,
            REG_PLANE_TOP, REG_PLANE_FAR, REG_PLANE_NEAR: begin
               plane_ff[csr_index] <= csr_pwdata;
            end
            REG_CULL_ENABLE: begin
               cull_enable_ff <= csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (csr_index) inside
         REG_PLANE_RIGHT, REG_PLANE_LEFT, REG_PLANE_BOTTOM,
         REG_PLANE_TOP, REG_PLANE_FAR, REG_PLANE_NEAR: begin
            csr_prdata = plane_ff[csr_index];
         end
         REG_CULL_ENABLE: begin
            csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cull_enable_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // ---------------- stall chain ----------------
   assign rdy4         = !out_v_ff || rsp_ch.ready;
   assign rdy3         = !v3_ff || rdy4;
   assign rdy2         = !v2_ff || rdy3;
   assign rdy1         = !v1_ff || rdy2;
   assign req_ch.ready = rdy1;

   assign first_c[0]  = req_ch.first_x;
   assign first_c[1]  = req_ch.first_y;
   assign first_c[2]  = req_ch.first_z;
   assign second_c[0] = req_ch.second_x;
   assign second_c[1] = req_ch.second_y;
   assign second_c[2] = req_ch.second_z;

   // ---------------- valid bits ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff    <= req_ch.valid;
         if (rdy2) v2_ff    <= v1_ff;
         if (rdy3) v3_ff    <= v2_ff;
         if (rdy4) out_v_ff <= v3_ff;
      end
   end

   // Stage 1: multiply each normal component by both corner coordinates
   always_ff @(posedge clock) begin
      if (req_ch.valid && rdy1) begin
         type1_ff   <= req_ch.req_type;
         radius1_ff <= req_ch.sphere_radius;
         for (int p = 0; p < NUM_PLANES; p++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
               prod_a_ff[p][k] <= prod_type'(normal_type'(plane_ff[p][63-16*k -: 16]))
                                * prod_type'(first_c[k]);
               prod_b_ff[p][k] <= prod_type'(normal_type'(plane_ff[p][63-16*k -: 16]))
                                * prod_type'(second_c[k]);
            end
         end
      end
   end

   // Stage 2: pick the larger corner term for boxes, fold radius into offset
   always_ff @(posedge clock) begin
      if (v1_ff && rdy2) begin
         type2_ff <= type1_ff;
         for (int p = 0; p < NUM_PLANES; p++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
               if (type1_ff == REQ_BOX && prod_b_ff[p][k] > prod_a_ff[p][k]) begin
                  term_ff[p][k] <= prod_b_ff[p][k];
               end else begin
                  term_ff[p][k] <= prod_a_ff[p][k];
               end
            end
            offset_ff[p] <= offset_type'(normal_type'(plane_ff[p][15:0]))
                          + ((type1_ff == REQ_SPHERE) ? offset_type'({2'b00, radius1_ff})
                                                      : offset_type'(0));
         end
      end
   end

   // Stage 3: partial sums, offset aligned to the product fraction bits
   always_ff @(posedge clock) begin
      if (v2_ff && rdy3) begin
         type3_ff <= type2_ff;
         for (int p = 0; p < NUM_PLANES; p++) begin
            part_a_ff[p] <= partial_type'(term_ff[p][0]) + partial_type'(term_ff[p][1]);
            part_b_ff[p] <= partial_type'(term_ff[p][2])
                          + (partial_type'(offset_ff[p]) <<< ALIGN_SHIFT);
         end
      end
   end

   // Final add and compare per plane; any culling plane hides the object, except a sphere while culling is disabled
   always_comb begin
      for (int p = 0; p < NUM_PLANES; p++) begin
         total[p] = total_type'(part_a_ff[p]) + total_type'(part_b_ff[p]);
         if (type3_ff == REQ_SPHERE) begin
            culled[p] = total[p][33] || (total[p] == '0);
         end else begin
            culled[p] = total[p][33];
         end
      end
      if (type3_ff == REQ_SPHERE && !cull_enable_ff) begin
         out_vis_in = 1'b1;
      end else begin
         out_vis_in = !(|culled);
      end
   end

   // Output register: hold while the consumer stalls
   always_ff @(posedge clock) begin
      if (v3_ff && rdy4) begin
         out_vis_ff  <= out_vis_in;
         out_type_ff <= type3_ff;
      end
   end

   assign rsp_ch.valid   = out_v_ff;
   assign rsp_ch.visible = out_vis_ff;

   // ---------------- assertions ----------------
   `FCSB_ASSERT_NR(a_reset_empties, $past(reset) |-> !out_v_ff, "output valid right after reset")
   `FCSB_ASSERT(a_out_from_s3, $rose(out_v_ff) |-> $past(v3_ff), "result appeared from empty stage")
   `FCSB_ASSERT(a_s1_advance, (v1_ff && rdy2) |=> v2_ff, "item lost between stage 1 and 2")
   `FCSB_ASSERT(a_sphere_no_cull,
      $past(v3_ff && rdy4 && type3_ff == REQ_SPHERE && !cull_enable_ff)
         |-> (out_vis_ff && out_type_ff == REQ_SPHERE),
      "sphere culled while culling disabled")

endmodule

// ===== sim/frustum_cull_checker.sv =====
// Checker for the frustum cull block: tracks the plane and cull-enable registers
// from the CSR write port, predicts each visibility result and compares it.
// Depends on fcsb_pkg, fcsb_req_if and fcsb_rsp_if.
module frustum_cull_checker (
   input  logic                   clock,
   input  logic                   reset,
   fcsb_req_if                    req_mon,
   fcsb_rsp_if                    rsp_mon,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic                   csr_pready,
   input  fcsb_pkg::csr_addr_type csr_paddr,
   input  fcsb_pkg::csr_data_type csr_pwdata,
   output int                     errors,
   output int                     outstanding
);
   import fcsb_pkg::*;

   localparam int REG_STRIDE_SHIFT = 3;
   localparam int CORNERS          = 8;

   plane_type     planes [NUM_PLANES];
   logic          cull_on;
   logic          expected_visible [$];
   logic          want;
   reg_index_type wr_index;

   // Signed distance of a point from a plane, with 14 fraction bits
   function automatic longint plane_distance(input plane_type p, input coord_type px,
                                             input coord_type py, input coord_type pz);
      normal_type nx;
      normal_type ny;
      normal_type nz;
      coord_type  plane_offset;
      nx           = p[63:48];
      ny           = p[47:32];
      nz           = p[31:16];
      plane_offset = p[15:0];
      return longint'(nx) * longint'(px) + longint'(ny) * longint'(py)
           + longint'(nz) * longint'(pz) + (longint'(plane_offset) <<< ALIGN_SHIFT);
   endfunction

   // Visibility of one sphere or box against the six planes
   function automatic logic predict_visible(input logic kind,
                                            input coord_type ax, input coord_type ay,
                                            input coord_type az, input coord_type bx,
                                            input coord_type by, input coord_type bz,
                                            input radius_type r);
      logic   vis;
      int     below;
      longint limit;
      vis   = 1'b1;
      limit = -(longint'(r) <<< ALIGN_SHIFT);
      for (int i = 0; i < NUM_PLANES; i++) begin
         if (kind == REQ_SPHERE) begin
            if (cull_on && plane_distance(planes[i], ax, ay, az) <= limit) vis = 1'b0;
         end else begin
            // culled only when every corner lies strictly behind the plane
            below = 0;
            for (int c = 0; c < CORNERS; c++) begin
               if (plane_distance(planes[i], (c & 1) ? bx : ax, (c & 2) ? by : ay,
                                  (c & 4) ? bz : az) < 0) below++;
            end
            if (below == CORNERS) vis = 1'b0;
         end
      end
      return vis;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) planes[i] = '0;
         cull_on = 1'b1;
         expected_visible.delete();
      end else begin
         // compare each result item with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_visible.size() == 0) begin
               $error("visible: expected nothing, actual %0b", rsp_mon.visible);
               errors <= errors + 1;
            end else begin
               want = expected_visible.pop_front();
               if (rsp_mon.visible !== want) begin
                  $error("visible: expected %0b, actual %0b", want, rsp_mon.visible);
                  errors <= errors + 1;
               end
            end
         end
         // predict each accepted request item and queue it at the tail
         if (req_mon.valid && req_mon.ready) begin
            expected_visible = {expected_visible, predict_visible(req_mon.req_type,
               req_mon.first_x, req_mon.first_y, req_mon.first_z,
               req_mon.second_x, req_mon.second_y, req_mon.second_z,
               req_mon.sphere_radius)};
         end
         // mirror register writes; unmapped indexes are dropped
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            wr_index = reg_index_type'(csr_paddr >> REG_STRIDE_SHIFT);
            if (wr_index < NUM_PLANES) planes[wr_index] = csr_pwdata;
            else if (wr_index == REG_CULL_ENABLE) cull_on = csr_pwdata[0];
         end
      end
      outstanding <= expected_visible.size();
   end

endmodule

// ===== sim/tb_frustum_cull_sphere_box_test.sv =====
// Testbench top for the frustum cull block: drives sphere and box items under
// several plane settings and idle patterns, and gives the verdict.
// Depends on fcsb_pkg, fcsb_req_if, fcsb_rsp_if and frustum_cull_checker.
module tb_frustum_cull_sphere_box_test;
   import fcsb_pkg::*;

   localparam int PHASES           = 8;
   localparam int ITEMS_PER_PHASE  = 225;
   localparam int WATCHDOG_LIMIT   = 1000;
   localparam int HOLDOFF_CYCLES   = 300;
   localparam int DRAIN_CYCLES     = 10;
   localparam int REG_STRIDE_SHIFT = 3;
   localparam int COORD_MAX        = 32767;
   localparam int COORD_MIN        = -32768;
   localparam int RADIUS_MAX       = 32767;
   localparam int UNIT_NORMAL      = 16384;
   localparam int WORLD_EDGE       = 5120;
   localparam int SCENE_REACH      = 10240;
   localparam int BOX_SPAN         = 4096;

   localparam reg_index_type REG_UNMAPPED = 3'd7;

   typedef enum int {
      CFG_RESET, CFG_AXIS, CFG_TILTED, CFG_NO_CULL,
      CFG_RANDOM, CFG_EXTREME, CFG_TILTED_NO_CULL, CFG_AXIS_JITTER
   } cfg_kind_type;

   typedef struct packed {
      logic                       req_type;
      coord_type [NUM_AXES-1:0]   first;
      coord_type [NUM_AXES-1:0]   second;
      radius_type                 sphere_radius;
   } bound_item_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   csr_addr_type csr_paddr;
   csr_data_type csr_pwdata;
   csr_data_type csr_prdata;
   logic         csr_pready;
   int           errors;
   int           outstanding;
   int           idle_pct;
   int           stall_pct;
   bit           hold_rsp;
   int           quiet_cycles;

   fcsb_req_if req_ch ();
   fcsb_rsp_if rsp_ch ();

   frustum_cull_sphere_box_test i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   frustum_cull_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .errors      (errors),
      .outstanding (outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bound_item_type make_bound(input logic kind, input int ax,
                                                 input int ay, input int az, input int bx,
                                                 input int by, input int bz, input int r);
      bound_item_type it;
      it.req_type      = kind;
      it.first         = {coord_type'(az), coord_type'(ay), coord_type'(ax)};
      it.second        = {coord_type'(bz), coord_type'(by), coord_type'(bx)};
      it.sphere_radius = radius_type'(r);
      return it;
   endfunction

   // Mostly scene-sized coordinates, some full range, some extremes
   function automatic coord_type pick_coord();
      case ($urandom_range(9))
         0: return coord_type'($urandom);
         1: return $urandom_range(1) ? coord_type'(COORD_MAX) : coord_type'(COORD_MIN);
         default: return coord_type'(int'($urandom_range(0, 2 * SCENE_REACH)) - SCENE_REACH);
      endcase
   endfunction

   function automatic radius_type pick_radius();
      case ($urandom_range(9))
         0: return radius_type'($urandom);
         1: return $urandom_range(1) ? radius_type'(RADIUS_MAX) : radius_type'(0);
         default: return radius_type'($urandom_range(0, 2048));
      endcase
   endfunction

   // Boxes are mostly well ordered; now and then an axis gets an unrelated maximum
   function automatic bound_item_type random_bound();
      bound_item_type it;
      it.req_type      = $urandom_range(1) ? REQ_BOX : REQ_SPHERE;
      it.sphere_radius = pick_radius();
      for (int a = 0; a < NUM_AXES; a++) begin
         it.first[a] = pick_coord();
         if ($urandom_range(7) == 0) it.second[a] = pick_coord();
         else it.second[a] = it.first[a] + coord_type'($urandom_range(0, BOX_SPAN));
      end
      return it;
   endfunction

   // Offer one item after a random idle stretch and hold it until accepted
   task automatic send_bound(input bound_item_type it);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.req_type      <= it.req_type;
      req_ch.first_x       <= it.first[0];
      req_ch.first_y       <= it.first[1];
      req_ch.first_z       <= it.first[2];
      req_ch.second_x      <= it.second[0];
      req_ch.second_y      <= it.second[1];
      req_ch.second_z      <= it.second[2];
      req_ch.sphere_radius <= it.sphere_radius;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Setup then access cycle; psel stays up for back-to-back writes
   task automatic csr_write(input reg_index_type idx, input csr_data_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= csr_addr_type'(idx) << REG_STRIDE_SHIFT;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic configure(input cfg_kind_type kind);
      plane_type    planes [NUM_PLANES];
      normal_type   nrm [NUM_AXES];
      int           reach;
      logic         cull_on;
      csr_data_type cull_word;
      cull_on = !(kind == CFG_NO_CULL || kind == CFG_TILTED_NO_CULL);
      for (int i = 0; i < NUM_PLANES; i++) begin
         case (kind) inside
            CFG_TILTED, CFG_TILTED_NO_CULL: begin
               for (int a = 0; a < NUM_AXES; a++)
                  nrm[a] = normal_type'(int'($urandom_range(0, 2 * UNIT_NORMAL)) - UNIT_NORMAL);
               reach = int'($urandom_range(0, 2 * WORLD_EDGE)) - WORLD_EDGE;
               planes[i] = {nrm[0], nrm[1], nrm[2], coord_type'(reach)};
            end
            CFG_RANDOM: planes[i] = {$urandom, $urandom};
            CFG_EXTREME: begin
               case (i)
                  0: planes[i] = 64'h8000_8000_8000_8000;
                  1: planes[i] = 64'h7FFF_7FFF_7FFF_7FFF;
                  2: planes[i] = 64'hFFFF_FFFF_FFFF_FFFF;
                  3: planes[i] = 64'h8000_8000_8000_7FFF;
                  4: planes[i] = 64'h7FFF_7FFF_7FFF_8000;
                  default: planes[i] = '0;
               endcase
            end
            default: begin
               // Axis-aligned cube: even planes face down an axis, odd planes face up
               for (int a = 0; a < NUM_AXES; a++) nrm[a] = '0;
               nrm[i / 2] = normal_type'((i % 2 == 0) ? -UNIT_NORMAL : UNIT_NORMAL);
               reach = (kind == CFG_AXIS_JITTER) ? $urandom_range(0, 2 * WORLD_EDGE)
                                                 : WORLD_EDGE;
               planes[i] = {nrm[0], nrm[1], nrm[2], coord_type'(reach)};
            end
         endcase
         csr_write(reg_index_type'(i), planes[i]);
      end
      // upper bits of the enable word are noise the block must drop
      cull_word    = {$urandom, $urandom};
      cull_word[0] = cull_on;
      csr_write(REG_CULL_ENABLE, cull_word);
      if (kind == CFG_NO_CULL || kind == CFG_RANDOM) csr_write(REG_UNMAPPED, {$urandom, $urandom});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Extremes, both kinds, inverted boxes and the plane boundary cases
   task automatic run_directed();
      send_bound(make_bound(REQ_SPHERE, 0, 0, 0, 0, 0, 0, 0));
      send_bound(make_bound(REQ_SPHERE, 0, 0, 0, 0, 0, 0, RADIUS_MAX));
      send_bound(make_bound(REQ_SPHERE, COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MIN, COORD_MIN, COORD_MIN, 0));
      send_bound(make_bound(REQ_SPHERE, COORD_MIN, COORD_MIN, COORD_MIN,
                            COORD_MAX, COORD_MAX, COORD_MAX, 1));
      send_bound(make_bound(REQ_BOX, -256, -256, -256, 256, 256, 256, 0));
      send_bound(make_bound(REQ_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                            COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX));
      send_bound(make_bound(REQ_BOX, COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MIN, COORD_MIN, COORD_MIN, 0));
      send_bound(make_bound(REQ_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                            COORD_MIN, COORD_MIN, COORD_MIN, 0));
      send_bound(make_bound(REQ_BOX, COORD_MAX, COORD_MAX, COORD_MAX,
                            COORD_MAX, COORD_MAX, COORD_MAX, 0));
      // sphere exactly at minus radius from the left plane, then one step inside
      send_bound(make_bound(REQ_SPHERE, -(WORLD_EDGE + 256), 0, 0, 0, 0, 0, 256));
      send_bound(make_bound(REQ_SPHERE, -(WORLD_EDGE + 255), 0, 0, 0, 0, 0, 256));
      // box touching the left plane, then one step beyond it
      send_bound(make_bound(REQ_BOX, -6000, -256, -256, -WORLD_EDGE, 256, 256, 0));
      send_bound(make_bound(REQ_BOX, -6000, -256, -256, -(WORLD_EDGE + 1), 256, 256, 0));
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: end the run when no item moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      cfg_kind_type cfg;
      idle_pct             = 0;
      stall_pct            = 0;
      hold_rsp             = 1'b0;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.req_type      <= REQ_SPHERE;
      req_ch.first_x       <= '0;
      req_ch.first_y       <= '0;
      req_ch.first_z       <= '0;
      req_ch.second_x      <= '0;
      req_ch.second_y      <= '0;
      req_ch.second_z      <= '0;
      req_ch.sphere_radius <= '0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         cfg = cfg_kind_type'(phase);
         if (cfg != CFG_RESET) configure(cfg);
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 65; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 65; end
            default: begin idle_pct = 33; stall_pct = 33; end
         endcase
         // back up the pipeline while the sender keeps offering
         if (cfg == CFG_RANDOM) hold_rsp = 1'b1;
         if (phase < 2) run_directed();
         repeat (ITEMS_PER_PHASE) send_bound(random_bound());
         req_ch.valid <= 1'b0;
         // let every result drain before touching the registers again
         do @(posedge clock); while (outstanding != 0);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end

      if (errors == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== frustum_cull_sphere_box_test.f =====
+incdir+src
src/fcsb_pkg.sv
src/fcsb_req_if.sv
src/fcsb_rsp_if.sv
src/frustum_cull_sphere_box_test.sv
sim/frustum_cull_checker.sv
sim/tb_frustum_cull_sphere_box_test.sv
